### sv/bwa_pkg.sv
// Shared types and constants of the burner window analytics block.
// Used by the controller, the datapath, the divider, the top level and the checker.
// No dependencies.
package bwa_pkg;

    // Channel widths (fields packed from bit 0 up, padded to whole bytes)
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_W       = 16;

    // Fixed-point field widths
    localparam int PWR_W   = 16;
    localparam int DLT_W   = 16;
    localparam int TS_W    = 32;
    localparam int START_W = 8;
    localparam int MIN_W   = 6;
    localparam int DUTY_W  = 7;
    localparam int CYC_W   = 17;

    // Reset value of the on threshold, 0.01 kW
    localparam logic [CFG_W-1:0] THRESH_RST = 16'd50;

    // Shared serial divider for the divisions by the window fill:
    // 32-bit dividend, 16-bit divisor, one bit per step
    localparam int DVD_W     = 32;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = 6;

    // Duty scale
    localparam logic [DVD_W-1:0] PERCENT = 32'd100;

    // Minutes from a sample count: n * 10 s / 60 s is n / 6, taken as
    // (n * ceil(2^18 / 6)) >> 18, exact for n below 2^17
    localparam int          SIXTH_SHIFT = 18;
    localparam logic [15:0] SIXTH_MUL   = 16'd43691;

    // Minutes from milliseconds: 60000 = 2^5 * 1875, so drop five bits and
    // take (x * ceil(2^38 / 1875)) >> 38, exact for the 27 bits left
    localparam int                  MS_DROP  = 5;
    localparam int                  MS_SHIFT = 38;
    localparam int                  MS_MUL_W = 28;
    localparam logic [MS_MUL_W-1:0] MS_MUL   = 28'd146601551;

    // Saturation limits
    localparam logic [DVD_W-1:0] START_MAX = 32'd255;
    localparam logic [DVD_W-1:0] MIN_MAX   = 32'd63;

    // Largest legal duty reading
    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    // Division jobs run after the window walk, in this order
    typedef enum logic [1:0] {
        DIV_POWER = 2'd0,
        DIV_DELTA = 2'd1,
        DIV_DUTY  = 2'd2
    } div_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      capture;
        logic      push;
        logic      walk_rd;
        logic      div_start;
        logic      div_store;
        logic      out_load;
        div_kind_t div_sel;
    } bwa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_last;
        logic div_done;
        logic out_free;
    } bwa_stat_t;

    // Next division job in the sequence
    function automatic div_kind_t next_div(input div_kind_t k);
        div_kind_t r;
        unique case (k)
            DIV_POWER: r = DIV_DELTA;
            DIV_DELTA: r = DIV_DUTY;
            DIV_DUTY:  r = DIV_POWER;
            default:   r = DIV_POWER;
        endcase
        return r;
    endfunction

endpackage

### sv/bwa_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on bwa_pkg for operand widths.
module bwa_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bwa_pkg::DVD_W-1:0]    dividend,
    input  logic [bwa_pkg::DVS_W-1:0]    divisor,
    output logic                         done,
    output logic [bwa_pkg::DVD_W-1:0]    quotient
);

    logic [bwa_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [bwa_pkg::DVD_W-1:0]     dvd_reg;
    logic [bwa_pkg::DVS_W-1:0]     dvs_reg;
    logic [bwa_pkg::DVS_W-1:0]     rem_reg;
    logic [bwa_pkg::DVS_W:0]       rem_sh;
    logic [bwa_pkg::DVS_W:0]       rem_sub;
    logic                          ge;
    logic [bwa_pkg::DVS_W-1:0]     rem_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[bwa_pkg::DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? rem_sub[bwa_pkg::DVS_W-1:0] : rem_sh[bwa_pkg::DVS_W-1:0];
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= bwa_pkg::DIV_CNT_W'(bwa_pkg::DVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == bwa_pkg::DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[bwa_pkg::DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### sv/bwa_ctrl.sv
// Sequencer of the burner window analytics block: push, walk, divide, output.
// Depends on bwa_pkg for the command and status structs.
module bwa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bwa_pkg::bwa_stat_t stat,
    output bwa_pkg::bwa_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PUSH     = 7'b0000010,
        ST_WALK     = 7'b0000100,
        ST_DRAIN    = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    bwa_pkg::div_kind_t    sel_reg;
    bwa_pkg::div_kind_t    sel_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                sel_next   = bwa_pkg::DIV_POWER;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    sel_next      = bwa_pkg::next_div(sel_reg);
                    state_next    = (sel_reg == bwa_pkg::DIV_DUTY) ? ST_OUT : ST_DIV_GO;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= bwa_pkg::DIV_POWER;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

### sv/bwa_dp.sv
// Datapath: sample ring memory, window accumulators, division jobs, result register.
// Depends on bwa_pkg and instantiates bwa_div.
module bwa_dp
#(
    parameter int WINDOW = 360
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bwa_pkg::bwa_cmd_t                  cmd,
    output bwa_pkg::bwa_stat_t                 stat,
    input  logic [bwa_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               cfg_valid,
    input  logic [bwa_pkg::CFG_W-1:0]          cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bwa_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int ADDR_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = bwa_pkg::PWR_W + CNT_W;
    localparam int ENT_W  = bwa_pkg::PWR_W + bwa_pkg::DLT_W;

    // Reciprocal multiplier widths for the minute conversions
    localparam int SIX_W    = 32;
    localparam int CYC_IN_W = bwa_pkg::TS_W - bwa_pkg::MS_DROP;
    localparam int CYC_P_W  = CYC_IN_W + bwa_pkg::MS_MUL_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);

    // Ring memory, one entry holds {delta, power}
    logic [ENT_W-1:0] ring_mem [WINDOW];

    // Configuration and captured sample
    logic [bwa_pkg::CFG_W-1:0]  thr_reg;
    logic [bwa_pkg::PWR_W-1:0]  pw_reg;
    logic [bwa_pkg::DLT_W-1:0]  dt_reg;
    logic [bwa_pkg::TS_W-1:0]   now_reg;

    // Window pointers and burner cycle state
    logic [ADDR_W-1:0]          wr_pos_reg;
    logic [ADDR_W-1:0]          wr_pos_next;
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    logic                       flag_reg;
    logic [bwa_pkg::TS_W-1:0]   cstart_reg;
    logic [bwa_pkg::CYC_W-1:0]  chold_reg;
    logic                       now_on;

    // Walk pointers and read stage
    logic [ADDR_W-1:0]          rd_ptr_reg;
    logic [CNT_W-1:0]           walk_cnt_reg;
    logic                       rd_valid_reg;
    logic [ENT_W-1:0]           rd_data_reg;

    // Accumulators
    logic [SUM_W-1:0]           sum_p_reg;
    logic [SUM_W-1:0]           sum_d_reg;
    logic [bwa_pkg::PWR_W-1:0]  peak_reg;
    logic [CNT_W-1:0]           on_cnt_reg;
    logic [CNT_W-1:0]           starts_reg;
    logic                       prev_on_reg;
    logic [bwa_pkg::PWR_W-1:0]  rd_pw;
    logic [bwa_pkg::DLT_W-1:0]  rd_dt;
    logic                       rd_on;

    // Division operands and results
    logic [SUM_W-1:0]           dmag;
    logic [bwa_pkg::DVD_W-1:0]  div_dvd;
    logic [bwa_pkg::DVS_W-1:0]  div_dvs;
    logic                       div_done;
    logic [bwa_pkg::DVD_W-1:0]  div_q;
    logic [bwa_pkg::PWR_W-1:0]  pmean_reg;
    logic [bwa_pkg::DLT_W-1:0]  dmean_reg;
    logic [bwa_pkg::DUTY_W-1:0] duty_reg;
    logic [bwa_pkg::MIN_W-1:0]  run_reg;
    logic [bwa_pkg::MIN_W-1:0]  idle_reg;
    logic [bwa_pkg::START_W-1:0] starts_sat;

    // Minute conversions by reciprocal multiplication
    logic [SIX_W-1:0]           run_prod;
    logic [SIX_W-1:0]           idle_prod;
    logic [bwa_pkg::MIN_W-1:0]  run_sat;
    logic [bwa_pkg::MIN_W-1:0]  idle_sat;
    logic [bwa_pkg::TS_W-1:0]   span;
    logic [CYC_P_W-1:0]         cyc_prod;
    logic [bwa_pkg::CYC_W-1:0]  cyc_min;

    // Output register
    logic                             out_valid_reg;
    logic [bwa_pkg::OUT_TDATA_W-1:0]  out_data_reg;

    // Pointer advance and fill growth
    always_comb
    begin
        wr_pos_next = (wr_pos_reg == LAST_ADDR) ? '0 : wr_pos_reg + 1'b1;
        fill_next   = (fill_reg == FULL_CNT) ? fill_reg : fill_reg + 1'b1;
        now_on      = (pw_reg >= thr_reg);
    end

    // Threshold register, written by the configuration channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= bwa_pkg::THRESH_RST;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Capture the accepted sample
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pw_reg  <= s_tdata[15:0];
            dt_reg  <= s_tdata[31:16];
            now_reg <= s_tdata[63:32];
        end
    end

    // Ring write on push, registered read during the walk
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[wr_pos_reg] <= {dt_reg, pw_reg};
        end
        if (cmd.walk_rd)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // Window and burner cycle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg   <= '0;
            fill_reg     <= '0;
            flag_reg     <= 1'b0;
            cstart_reg   <= '0;
            chold_reg    <= '0;
            rd_ptr_reg   <= '0;
            walk_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.walk_rd;
            if (cmd.push)
            begin
                wr_pos_reg   <= wr_pos_next;
                fill_reg     <= fill_next;
                // oldest entry is slot zero until the window wraps
                rd_ptr_reg   <= (fill_next == FULL_CNT) ? wr_pos_next : '0;
                walk_cnt_reg <= '0;
                if (now_on != flag_reg)
                begin
                    flag_reg   <= now_on;
                    cstart_reg <= now_reg;
                end
            end
            else if (cmd.walk_rd)
            begin
                rd_ptr_reg   <= (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
            end
            // hold the last cycle length until a state change has happened
            if (cmd.div_store && (cmd.div_sel == bwa_pkg::DIV_DUTY) && (cstart_reg != '0))
            begin
                chold_reg <= cyc_min;
            end
        end
    end

    // Split the read entry and classify it
    always_comb
    begin
        rd_pw = rd_data_reg[bwa_pkg::PWR_W-1:0];
        rd_dt = rd_data_reg[ENT_W-1:bwa_pkg::PWR_W];
        rd_on = (rd_pw >= thr_reg);
    end

    // Accumulate over the window, oldest first
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            sum_p_reg   <= '0;
            sum_d_reg   <= '0;
            peak_reg    <= '0;
            on_cnt_reg  <= '0;
            starts_reg  <= '0;
            prev_on_reg <= 1'b0;
        end
        else if (rd_valid_reg)
        begin
            sum_p_reg   <= sum_p_reg + SUM_W'(rd_pw);
            sum_d_reg   <= sum_d_reg + {{CNT_W{rd_dt[bwa_pkg::DLT_W-1]}}, rd_dt};
            peak_reg    <= (rd_pw > peak_reg) ? rd_pw : peak_reg;
            prev_on_reg <= rd_on;
            if (rd_on)
            begin
                on_cnt_reg <= on_cnt_reg + 1'b1;
                if (!prev_on_reg)
                begin
                    starts_reg <= starts_reg + 1'b1;
                end
            end
        end
    end

    // Select the operands of the current division job
    always_comb
    begin
        dmag = sum_d_reg[SUM_W-1] ? (~sum_d_reg + 1'b1) : sum_d_reg;
        unique case (cmd.div_sel)
            bwa_pkg::DIV_POWER:
            begin
                div_dvd = bwa_pkg::DVD_W'(sum_p_reg);
                div_dvs = bwa_pkg::DVS_W'(fill_reg);
            end
            bwa_pkg::DIV_DELTA:
            begin
                div_dvd = bwa_pkg::DVD_W'(dmag);
                div_dvs = bwa_pkg::DVS_W'(fill_reg);
            end
            bwa_pkg::DIV_DUTY:
            begin
                div_dvd = bwa_pkg::DVD_W'(on_cnt_reg) * bwa_pkg::PERCENT;
                div_dvs = bwa_pkg::DVS_W'(fill_reg);
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = bwa_pkg::DVS_W'(fill_reg);
            end
        endcase
    end

    bwa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Convert counts and elapsed time to minutes, saturate the counters
    always_comb
    begin
        run_prod   = SIX_W'(on_cnt_reg) * SIX_W'(bwa_pkg::SIXTH_MUL);
        idle_prod  = SIX_W'(fill_reg - on_cnt_reg) * SIX_W'(bwa_pkg::SIXTH_MUL);
        run_sat    = ((run_prod >> bwa_pkg::SIXTH_SHIFT) > bwa_pkg::MIN_MAX) ?
                     '1 : run_prod[bwa_pkg::SIXTH_SHIFT +: bwa_pkg::MIN_W];
        idle_sat   = ((idle_prod >> bwa_pkg::SIXTH_SHIFT) > bwa_pkg::MIN_MAX) ?
                     '1 : idle_prod[bwa_pkg::SIXTH_SHIFT +: bwa_pkg::MIN_W];
        span       = now_reg - cstart_reg;
        cyc_prod   = CYC_P_W'(span[bwa_pkg::TS_W-1:bwa_pkg::MS_DROP]) *
                     CYC_P_W'(bwa_pkg::MS_MUL);
        cyc_min    = cyc_prod[CYC_P_W-1:bwa_pkg::MS_SHIFT];
        starts_sat = (bwa_pkg::DVD_W'(starts_reg) > bwa_pkg::START_MAX) ?
                     '1 : bwa_pkg::START_W'(starts_reg);
    end

    // Store each division result, minutes with the last job
    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            unique case (cmd.div_sel)
                bwa_pkg::DIV_POWER: pmean_reg <= div_q[bwa_pkg::PWR_W-1:0];
                bwa_pkg::DIV_DELTA: dmean_reg <= sum_d_reg[SUM_W-1] ?
                                                 (~div_q[bwa_pkg::DLT_W-1:0] + 1'b1) :
                                                 div_q[bwa_pkg::DLT_W-1:0];
                bwa_pkg::DIV_DUTY:
                begin
                    duty_reg <= div_q[bwa_pkg::DUTY_W-1:0];
                    run_reg  <= run_sat;
                    idle_reg <= idle_sat;
                end
                default: ;
            endcase
        end
    end

    // Output register: load when free, drop valid once the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {3'b000, chold_reg, flag_reg, duty_reg, idle_reg, run_reg,
                             starts_sat, dmean_reg, peak_reg, pmean_reg};
        end
    end

    assign stat.walk_last = (walk_cnt_reg == fill_reg - 1'b1);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;

endmodule

### sv/burner_window_analytics_unit.sv
// Burner window analytics: one result per 10-second sample over a ring window.
// From accepted sample to result valid the steps are:
// push, window walk one entry per cycle through the ring memory read port, drain,
// three jobs on the shared divider (power mean, delta mean, duty), output load.
// No new sample until the last result is loaded; input is taken again while a result waits.
// Reset (rst_n, async, low): empty window, threshold 50, burner off, cycle time zero.
module burner_window_analytics_unit
#(
    parameter int WINDOW = 360
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] power_sample, [31:16] temp_delta, [63:32] now_ms
    input  logic [bwa_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] power_mean, [31:16] power_peak, [47:32] delta_mean, [55:48] start_count,
    // [61:56] run_minutes, [67:62] idle_minutes, [74:68] duty_percent,
    // [75] burner_running, [92:76] cycle_minutes, [95:93] zero
    output logic [bwa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    // on_threshold
    input  logic [bwa_pkg::CFG_W-1:0]        cfg_data
);

    bwa_pkg::bwa_cmd_t  cmd;
    bwa_pkg::bwa_stat_t stat;

    // Threshold writes complete at once
    assign cfg_ready = 1'b1;

    bwa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bwa_dp
    #(
        .WINDOW (WINDOW)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### sv/bwa_chk.sv
// Port-level checker for burner_window_analytics_unit, attached by bind.
// Depends on bwa_pkg for the channel widths.
module bwa_chk
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [bwa_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    // Track transactions accepted but not yet delivered
    always_comb
    begin
        in_acc    = s_tvalid && s_tready;
        out_acc   = m_tvalid && m_tready;
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // No result without an accepted sample behind it
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result shown with no sample outstanding");

    // One sample at a time: input closes right after a transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is still in work");

    // At most one sample in work and one result waiting
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many samples outstanding");

    // Duty never exceeds one hundred percent
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[74:68] <= bwa_pkg::DUTY_MAX)
        else $error("duty percent out of range");

endmodule

bind burner_window_analytics_unit bwa_chk u_bwa_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
